[sv/mcg_pkg.sv]
// Shared constants and control types for the midpoint circle generator.
// No dependencies; used by mcg_walker, mcg_emit and the top level.
`default_nettype none

package mcg_pkg;

   // Default geometry.
   localparam int COORD_BITS_DEF  = 12;
   localparam int RADIUS_BITS_DEF = 11;

   // Midpoint decision constants.
   localparam int DEC_INIT     = 3;   // 3 - 2r at ring start
   localparam int DEC_INC_HOLD = 6;   // 4x + 6 when the major offset holds
   localparam int DEC_INC_MOVE = 10;  // 4(x - y) + 10 when it steps in

   // Request kinds carried in req_tuser.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Number of symmetric points per step.
   localparam int OCTANTS = 8;

   // Walker to emitter: load a new burst of points.
   typedef struct packed {
      logic load;
      logic is_last;
   } step_ctl_type;

   // Emitter status seen by the top level.
   typedef struct packed {
      logic       busy;
      logic       pop;
      logic       done;
      logic [2:0] octant;
   } emit_stat_type;

endpackage

`default_nettype wire

[sv/mcg_walker.sv]
// Circle state and midpoint update: latches start requests and advances offsets.
// Depends on mcg_pkg.
`default_nettype none

module mcg_walker #(
   parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_fire,
   input  wire logic                     action,
   input  wire logic [COORD_BITS-1:0]    center_x,
   input  wire logic [COORD_BITS-1:0]    center_y,
   input  wire logic [RADIUS_BITS-1:0]   radius,
   input  wire logic                     filled,
   output mcg_pkg::step_ctl_type         step_ctl,
   output logic      [COORD_BITS-1:0]    cur_cx,
   output logic      [COORD_BITS-1:0]    cur_cy,
   output logic      [RADIUS_BITS-1:0]   cur_minor,
   output logic      [RADIUS_BITS:0]     cur_major
);

   localparam int R = RADIUS_BITS;
   localparam int D = RADIUS_BITS + 5;

   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [R-1:0]          ring_ff, ring_in, minor_ff, minor_in;
   logic [R:0]            major_ff, major_in;
   logic [D-1:0]          dec_ff, dec_in;
   logic                  fill_ff, fill_in, busy_ff, busy_in;

   logic                  dec_neg;
   logic [R+1:0]          diff;
   logic [R+1:0]          x_next, y_next;
   logic [D-1:0]          dec_hold, dec_move;
   logic [R-1:0]          ring_dn;

   // Midpoint update terms
   always_comb begin
      dec_neg  = dec_ff[D-1];
      diff     = {2'b00, minor_ff} - {1'b0, major_ff};
      dec_hold = dec_ff + D'({minor_ff, 2'b00}) + D'(mcg_pkg::DEC_INC_HOLD);
      dec_move = dec_ff + {{(D-R-4){diff[R+1]}}, diff, 2'b00}
                 + D'(mcg_pkg::DEC_INC_MOVE);
      x_next   = {2'b00, minor_ff} + (R+2)'(1);
      y_next   = {1'b0, major_ff} - (R+2)'(!dec_neg);
      ring_dn  = ring_ff - R'(1);
   end

   // Next state
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      ring_in  = ring_ff;
      minor_in = minor_ff;
      major_in = major_ff;
      dec_in   = dec_ff;
      fill_in  = fill_ff;
      busy_in  = busy_ff;
      step_ctl = '0;
      priority if (req_fire && action == mcg_pkg::ACT_START) begin
         cx_in    = center_x;
         cy_in    = center_y;
         fill_in  = filled;
         ring_in  = radius;
         minor_in = '0;
         major_in = {1'b0, radius};
         dec_in   = D'(mcg_pkg::DEC_INIT) - D'({radius, 1'b0});
         busy_in  = !(filled && radius == '0);
      end else if (req_fire && busy_ff) begin
         step_ctl.load = 1'b1;
         dec_in = dec_neg ? dec_hold : dec_move;
         if ($signed(x_next) <= $signed(y_next)) begin
            minor_in = x_next[R-1:0];
            major_in = y_next[R:0];
         end else if (fill_ff && ring_ff > R'(1)) begin
            ring_in  = ring_dn;
            minor_in = '0;
            major_in = {1'b0, ring_dn};
            dec_in   = D'(mcg_pkg::DEC_INIT) - D'({ring_dn, 1'b0});
         end else begin
            busy_in          = 1'b0;
            step_ctl.is_last = 1'b1;
         end
      end else begin
         busy_in = busy_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fill_ff  <= 1'b0;
         ring_ff  <= '0;
         minor_ff <= '0;
         major_ff <= '0;
         dec_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
      end else begin
         busy_ff  <= busy_in;
         fill_ff  <= fill_in;
         ring_ff  <= ring_in;
         minor_ff <= minor_in;
         major_ff <= major_in;
         dec_ff   <= dec_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

   assign cur_cx    = cx_ff;
   assign cur_cy    = cy_ff;
   assign cur_minor = minor_ff;
   assign cur_major = major_ff;

endmodule

`default_nettype wire

[sv/mcg_emit.sv]
// Point buffer: forms the eight symmetric points of one step and sends them in order.
// Depends on mcg_pkg.
`default_nettype none

module mcg_emit #(
   parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mcg_pkg::step_ctl_type      step_ctl,
   input  wire logic   [COORD_BITS-1:0]    cur_cx,
   input  wire logic   [COORD_BITS-1:0]    cur_cy,
   input  wire logic   [RADIUS_BITS-1:0]   cur_minor,
   input  wire logic   [RADIUS_BITS:0]     cur_major,
   input  wire logic                       out_ready,
   output logic                            out_valid,
   output logic signed [COORD_BITS+1:0]    out_x,
   output logic signed [COORD_BITS+1:0]    out_y,
   output logic        [2:0]               out_octant,
   output logic                            out_last,
   output mcg_pkg::emit_stat_type          stat
);

   localparam int P = COORD_BITS + 2;

   logic [P-1:0] px_ff [mcg_pkg::OCTANTS];
   logic [P-1:0] py_ff [mcg_pkg::OCTANTS];
   logic [P-1:0] px_in [mcg_pkg::OCTANTS];
   logic [P-1:0] py_in [mcg_pkg::OCTANTS];
   logic [P-1:0] cxw, cyw, xw, yw;
   logic         valid_ff, valid_in, last_ff, last_in;
   logic [2:0]   oct_ff, oct_in;
   logic         pop, done;

   // Eight symmetric points, wrapped to the point width
   always_comb begin
      cxw = P'(cur_cx);
      cyw = P'(cur_cy);
      xw  = P'(cur_minor);
      yw  = P'(cur_major);
      px_in[0] = cxw + xw;  py_in[0] = cyw + yw;
      px_in[1] = cxw - xw;  py_in[1] = cyw + yw;
      px_in[2] = cxw + xw;  py_in[2] = cyw - yw;
      px_in[3] = cxw - xw;  py_in[3] = cyw - yw;
      px_in[4] = cxw + yw;  py_in[4] = cyw + xw;
      px_in[5] = cxw - yw;  py_in[5] = cyw + xw;
      px_in[6] = cxw + yw;  py_in[6] = cyw - xw;
      px_in[7] = cxw - yw;  py_in[7] = cyw - xw;
   end

   // Sequencer: advance one octant per taken result
   always_comb begin
      pop      = valid_ff && out_ready;
      done     = pop && oct_ff == 3'd7;
      valid_in = valid_ff;
      last_in  = last_ff;
      oct_in   = oct_ff;
      if (pop) begin
         oct_in = oct_ff + 3'd1;
      end
      if (done) begin
         valid_in = 1'b0;
      end
      if (step_ctl.load) begin
         valid_in = 1'b1;
         last_in  = step_ctl.is_last;
         oct_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         oct_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
         oct_ff   <= oct_in;
      end
   end

   // Hold point payload until the next step loads
   always_ff @(posedge clock) begin
      if (step_ctl.load) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_x       = px_ff[oct_ff];
   assign out_y       = py_ff[oct_ff];
   assign out_octant  = oct_ff;
   assign out_last    = last_ff && oct_ff == 3'd7;
   assign stat.busy   = valid_ff;
   assign stat.pop    = pop;
   assign stat.done   = done;
   assign stat.octant = oct_ff;

endmodule

`default_nettype wire

[sv/midpoint_circle_generator_core.sv]
// Midpoint circle generator: usage notes
//
// Request channel (req_*): req_tuser selects the kind, start (0) or step (1).
// A start latches center, radius and filled mode from req_tdata and returns
// nothing; a start while a circle is running restarts it. A step returns the
// eight symmetric points of the current offset pair, then updates the offsets.
// A step while idle returns nothing. Filled mode walks rings from the radius
// down to 1; rsp_tlast marks the final point of the circle or disk.
// Response channel (rsp_*): one point per transfer, octants 0..7 in order.
// Latency: the first point of a step is valid the cycle after it is accepted.
// Flow: steps share the single response port that carries their eight
// points; a new request is taken in the same cycle that the eighth point
// leaves, so steps flow with no gap. Starts are taken whenever the point
// buffer is free or draining its last point.
// Reset (synchronous, active high) leaves the generator idle and the point
// buffer empty. When the receiver stalls, the current point holds and
// req_tready stays low until the buffered step is drained.
// Depends on mcg_pkg, mcg_walker and mcg_emit.
`default_nettype none

module midpoint_circle_generator_core #(
   parameter int COORD_BITS  = mcg_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mcg_pkg::RADIUS_BITS_DEF,
   localparam int IN_W  = ((2*COORD_BITS + RADIUS_BITS + 1 + 7) / 8) * 8,
   localparam int OUT_W = ((2*(COORD_BITS + 2) + 3 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // center_x, center_y, radius, filled (lowest bits first), zero padded
   input  wire logic [IN_W-1:0]  req_tdata,
   // action: start or step
   input  wire logic             req_tuser,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // point_x, point_y, octant (lowest bits first), zero padded
   output logic [OUT_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready
);

   localparam int C = COORD_BITS;
   localparam int R = RADIUS_BITS;
   localparam int P = COORD_BITS + 2;

   mcg_pkg::step_ctl_type  step_ctl;
   mcg_pkg::emit_stat_type stat;
   logic                   req_fire;
   logic [C-1:0]           cur_cx, cur_cy;
   logic [R-1:0]           cur_minor;
   logic [R:0]             cur_major;
   logic signed [P-1:0]    pt_x, pt_y;
   logic [2:0]             pt_oct;

   // Take a request when the point buffer is free or emptying
   assign req_tready = !stat.busy || stat.done;
   assign req_fire   = req_tvalid && req_tready;

   mcg_walker #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .action    (req_tuser),
      .center_x  (req_tdata[C-1:0]),
      .center_y  (req_tdata[2*C-1:C]),
      .radius    (req_tdata[2*C+R-1:2*C]),
      .filled    (req_tdata[2*C+R]),
      .step_ctl  (step_ctl),
      .cur_cx    (cur_cx),
      .cur_cy    (cur_cy),
      .cur_minor (cur_minor),
      .cur_major (cur_major)
   );

   mcg_emit #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .step_ctl   (step_ctl),
      .cur_cx     (cur_cx),
      .cur_cy     (cur_cy),
      .cur_minor  (cur_minor),
      .cur_major  (cur_major),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_x      (pt_x),
      .out_y      (pt_y),
      .out_octant (pt_oct),
      .out_last   (rsp_tlast),
      .stat       (stat)
   );

   // Pack the response
   assign rsp_tdata = OUT_W'({pt_oct, pt_y, pt_x});

   // A step is never accepted over points still waiting to leave
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_ctl.load) |-> (!stat.busy || stat.done))
      else $error("step loaded over undrained points");

   // The last flag only rides on the eighth point
   a_last_octant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (stat.octant == 3'd7))
      else $error("last flag on a point other than the eighth");

   // A fresh burst always starts at octant zero
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      step_ctl.load |=> (rsp_tvalid && stat.octant == 3'd0))
      else $error("burst did not start at octant zero");

   // A stalled point keeps its octant
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(stat.octant)))
      else $error("octant moved while stalled");

endmodule

`default_nettype wire

[verif/midpoint_circle_generator_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for midpoint_circle_generator_core: drives start and
// step requests, predicts every emitted point in a scoreboard class and checks
// the response stream field by field. Depends on mcg_pkg and the generator RTL.

module midpoint_circle_generator_core_tb;

   // One expected or observed point on the response channel
   typedef struct packed {
      logic [13:0] px;
      logic [13:0] py;
      logic [2:0]  octant;
      logic        last;
   } point_type;

   // Predicts the generator and holds the points still owed by the block
   class circle_scoreboard;
      logic [11:0]        ctr_x;
      logic [11:0]        ctr_y;
      logic [10:0]        ring_r;
      logic [10:0]        minor;
      logic [11:0]        major;
      logic signed [15:0] decision;
      logic               fill;
      logic               busy;
      point_type          pending[$];
      int                 n_points;
      int                 n_errors;

      function new();
         ctr_x = '0;
         ctr_y = '0;
         ring_r = '0;
         minor = '0;
         major = '0;
         decision = '0;
         fill = 1'b0;
         busy = 1'b0;
         n_points = 0;
         n_errors = 0;
      endfunction

      // Start a ring: offsets (0, r), decision 3 - 2r
      function void load_ring(logic [10:0] r);
         ring_r = r;
         minor = '0;
         major = {1'b0, r};
         decision = 16'(mcg_pkg::DEC_INIT - 2 * int'(r));
      endfunction

      // Note an accepted request; returns the number of points it owes
      function int note(logic act, logic [11:0] cx, logic [11:0] cy, logic [10:0] r,
                        logic fl);
         int        x;
         int        y;
         int        nx;
         int        ny;
         int        d;
         int        a;
         int        b;
         logic      last_step;
         point_type pt;
         if (act == mcg_pkg::ACT_START) begin
            ctr_x = cx;
            ctr_y = cy;
            fill = fl;
            load_ring(r);
            busy = !(fl && r == 0);
            return 0;
         end
         if (!busy)
            return 0;
         x = minor;
         y = major;
         d = decision;
         ny = y;
         // midpoint update
         if (decision < 0) begin
            d = d + 4 * x + mcg_pkg::DEC_INC_HOLD;
         end else begin
            d = d + 4 * (x - y) + mcg_pkg::DEC_INC_MOVE;
            ny = y - 1;
         end
         nx = x + 1;
         decision = 16'(d);
         last_step = 1'b0;
         if (nx <= ny) begin
            minor = 11'(nx);
            major = 12'(ny);
         end else if (fill && ring_r > 1) begin
            load_ring(ring_r - 11'd1);
         end else begin
            busy = 1'b0;
            last_step = 1'b1;
         end
         // eight symmetric points of the old offset pair
         for (int k = 0; k < mcg_pkg::OCTANTS; k++) begin
            a = (k < 4) ? x : y;
            b = (k < 4) ? y : x;
            pt.px = 14'(int'(ctr_x) + ((k % 2 == 1) ? -a : a));
            pt.py = 14'(int'(ctr_y) + (((k / 2) % 2 == 1) ? -b : b));
            pt.octant = 3'(k);
            pt.last = last_step && (k == mcg_pkg::OCTANTS - 1);
            pending.insert(pending.size(), pt);
         end
         return mcg_pkg::OCTANTS;
      endfunction

      task report(string msg);
         if (n_errors < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
         n_errors++;
      endtask

      // Compare one accepted point with the oldest expectation
      task check(point_type got);
         point_type want;
         n_points++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected point x=%0d y=%0d octant=%0d",
                             $signed(got.px), $signed(got.py), got.octant));
            return;
         end
         want = pending.pop_front();
         if (got.px !== want.px)
            report($sformatf("point_x %0d, want %0d (octant %0d)",
                             $signed(got.px), $signed(want.px), want.octant));
         if (got.py !== want.py)
            report($sformatf("point_y %0d, want %0d (octant %0d)",
                             $signed(got.py), $signed(want.py), want.octant));
         if (got.octant !== want.octant)
            report($sformatf("octant %0d, want %0d", got.octant, want.octant));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b (octant %0d)",
                             got.last, want.last, want.octant));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [39:0] req_tdata = '0;   // center_x, center_y, radius, filled, zero pad
   logic        req_tuser = 1'b0; // action: start or step
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;        // point_x, point_y, octant, zero pad
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   circle_scoreboard sb = new();
   bit calm = 1'b0;
   int n_effective = 0;
   int n_starts = 0;
   int n_steps = 0;

   midpoint_circle_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // Stall the receiver at random, except during the calm stretch
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || ($urandom_range(0, 99) >= 11);
   end

   // Check every accepted point
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check({rsp_tdata[13:0], rsp_tdata[27:14], rsp_tdata[30:28], rsp_tlast});
   end

   // Drive one request, with random idle cycles ahead of it
   task automatic send_request(input logic act, input logic [11:0] cx,
                               input logic [11:0] cy, input logic [10:0] r,
                               input logic fl);
      calm = (n_effective >= 150 && n_effective < 230);
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'b0, fl, r, cy, cx};
      do
         @(posedge clock);
      while (!req_tready);
      if (act == mcg_pkg::ACT_START)
         n_starts++;
      else
         n_steps++;
      if (sb.note(act, cx, cy, r, fl) > 0 || act == mcg_pkg::ACT_START)
         n_effective++;
   endtask

   // Step with junk operands, which the block ignores
   task automatic send_step();
      send_request(mcg_pkg::ACT_STEP, 12'($urandom), 12'($urandom), 11'($urandom),
                   1'($urandom));
   endtask

   // Start a circle and step it until done or until max_steps
   task automatic run_circle(input logic [11:0] cx, input logic [11:0] cy,
                             input logic [10:0] r, input logic fl, input int max_steps);
      int steps = 0;
      send_request(mcg_pkg::ACT_START, cx, cy, r, fl);
      while (sb.busy && steps < max_steps) begin
         send_step();
         steps++;
      end
   endtask

   // Mostly complete circles with random content, some cut short, some noise
   task automatic random_circle();
      int          pick;
      logic [11:0] cx;
      logic [11:0] cy;
      pick = $urandom_range(0, 99);
      cx = 12'($urandom);
      cy = 12'($urandom);
      if (pick < 45)
         run_circle(cx, cy, 11'($urandom_range(0, 24)), 1'b0, 1000);
      else if (pick < 70)
         run_circle(cx, cy, 11'($urandom_range(0, 10)), 1'b1, 1000);
      else if (pick < 80)
         run_circle(cx, cy, 11'($urandom), 1'($urandom), $urandom_range(1, 6));
      else if (pick < 90)
         run_circle(cx, cy, 11'($urandom_range(1, 24)), 1'($urandom),
                    $urandom_range(1, 4));
      else if (pick < 95)
         send_step();
      else
         send_request(mcg_pkg::ACT_START, cx, cy, 11'($urandom), 1'($urandom));
      // trailing step, often on an idle generator
      if ($urandom_range(0, 3) == 0)
         send_step();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_step();                                   // step while idle
      run_circle(12'd0, 12'd0, 11'd0, 1'b0, 4);      // outline radius zero
      send_step();
      run_circle(12'hFFF, 12'hFFF, 11'd0, 1'b1, 4);  // filled radius zero stays idle
      send_step();
      run_circle(12'hFFF, 12'd0, 11'd2, 1'b1, 8);
      run_circle(12'hFFF, 12'hFFF, 11'h7FF, 1'b0, 3);
      run_circle(12'd0, 12'd0, 11'h7FF, 1'b1, 2);    // restart while busy
      run_circle(12'h800, 12'h800, 11'h400, 1'b1, 2);
      run_circle(12'd0, 12'hFFF, 11'd3, 1'b1, 100);

      // random part
      while (n_effective < 350)
         random_circle();
      req_tvalid <= 1'b0;

      // drain, then watch for stray points
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d requests (%0d starts, %0d steps), %0d points checked",
               n_starts + n_steps, n_starts, n_steps, sb.n_points);
      if (sb.n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #(2_000_000);
      $display("Timeout with %0d points outstanding", sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
